### hdl/deq_pkg.sv
// Shared types and constants of the double-ended queue with search.
`timescale 1ns / 1ps

package deq_pkg;

  localparam int unsigned MODE_W    = 3;
  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned POS_W     = 6;
  localparam int unsigned CNT_W     = 7;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned S_TDATA_W = 40;  // value, position, padding
  localparam int unsigned M_TDATA_W = 48;  // value, found position, count, padding

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_BACK   = 3'd3,
    MODE_FIND       = 3'd4,
    MODE_READ_POS   = 3'd5
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_MISS  = 2'd3
  } status_e;

  // Controller to datapath.
  typedef struct packed {
    logic latch;       // capture the request beat
    logic rd_start;    // issue the single read of a pop or indexed read
    logic scan_start;  // set up the search walk
    logic scan_step;   // advance the search walk by one step
    logic commit;      // update pointers, write memory, load output register
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic need_read;
    logic need_scan;
    logic scan_done;
    logic out_free;
  } dp_sts_t;

endpackage

### hdl/deq_ram.sv
// Generic simple dual-port RAM with registered read data.
`timescale 1ns / 1ps

module deq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/deq_ctrl.sv
// Sequencing state machine of the double-ended queue.
`timescale 1ns / 1ps

module deq_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  output logic             req_ready_o,
  input  deq_pkg::dp_sts_t sts_i,
  output deq_pkg::dp_cmd_t cmd_o
);
  import deq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_FIN
  } state_e;

  state_e  state_q, state_d;
  dp_cmd_t cmd;

  always_comb begin
    cmd     = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          cmd.latch = 1'b1;
          state_d   = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts_i.need_read) begin
          cmd.rd_start = 1'b1;
          state_d      = S_FIN;
        end else if (sts_i.need_scan) begin
          cmd.scan_start = 1'b1;
          state_d        = S_SCAN;
        end else begin
          state_d = S_FIN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts_i.scan_done) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        // hold the result until the output register can take it
        if (sts_i.out_free) begin
          cmd.commit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign req_ready_o = (state_q == S_IDLE);
  assign cmd_o       = cmd;

endmodule

### hdl/deq_dp.sv
// Datapath: ring pointers, entry memory, search walk and output register.
`timescale 1ns / 1ps

module deq_dp #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  deq_pkg::dp_cmd_t               cmd_i,
  output deq_pkg::dp_sts_t               sts_o,
  input  logic [deq_pkg::MODE_W-1:0]     req_mode_i,
  input  logic [deq_pkg::VALUE_W-1:0]    req_value_i,
  input  logic [deq_pkg::POS_W-1:0]      req_pos_i,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic [deq_pkg::STATUS_W-1:0]   out_status_o,
  output logic [deq_pkg::VALUE_W-1:0]    out_value_o,
  output logic [deq_pkg::POS_W-1:0]      out_fpos_o,
  output logic [deq_pkg::CNT_W-1:0]      out_count_o
);
  import deq_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = CW + 1;
  localparam int unsigned XW = (CW > POS_W) ? CW : POS_W;

  // ring slot of the entry 'off' places behind 'base'; the sum stays below 2*DEPTH
  function automatic logic [PW-1:0] slot_f(input logic [PW-1:0] base,
                                           input logic [CW-1:0] off);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(off);
    if (sum >= SW'(DEPTH)) begin
      sum = sum - SW'(DEPTH);
    end
    return sum[PW-1:0];
  endfunction

  function automatic logic [PW-1:0] inc_f(input logic [PW-1:0] p);
    logic [PW-1:0] r;
    if (p == PW'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PW'(1);
    end
    return r;
  endfunction

  // request
  logic [MODE_W-1:0]  mode_q;
  logic [VALUE_W-1:0] val_q;
  logic [POS_W-1:0]   pos_q;

  // ring state
  logic [PW-1:0] fp_q, fp_d;
  logic [CW-1:0] cnt_q, cnt_d;

  // search walk
  logic [CW-1:0] iss_q, iss_d;
  logic [PW-1:0] addr_q, addr_d;
  logic          cmp_vld_q, cmp_vld_d;
  logic [PW-1:0] cmp_idx_q, cmp_idx_d;
  logic          hit_q, hit_d;
  logic [PW-1:0] hit_pos_q, hit_pos_d;

  // output register
  logic                out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] out_status_q;
  logic [VALUE_W-1:0]  out_value_q;
  logic [POS_W-1:0]    out_fpos_q;
  logic [CNT_W-1:0]    out_count_q;

  // memory port
  logic               we;
  logic [PW-1:0]      waddr;
  logic               re;
  logic [PW-1:0]      raddr;
  logic [VALUE_W-1:0] rd_data;

  logic          full, empty, pos_out, issue, val_eq;
  logic [CW-1:0] cnt_m1, rd_off;
  logic [PW-1:0] fp_dec;

  logic [STATUS_W-1:0] res_status;
  logic [VALUE_W-1:0]  res_value;
  logic [POS_W-1:0]    res_fpos;

  assign full    = (cnt_q == CW'(DEPTH));
  assign empty   = (cnt_q == '0);
  assign pos_out = (XW'(pos_q) >= XW'(cnt_q));
  assign cnt_m1  = cnt_q - CW'(1);
  assign fp_dec  = (fp_q == '0) ? PW'(DEPTH - 1) : fp_q - PW'(1);
  assign issue   = (iss_q < cnt_q);
  assign val_eq  = (rd_data == val_q);

  always_comb begin
    case (mode_q)
      MODE_POP_BACK: rd_off = cnt_m1;
      MODE_READ_POS: rd_off = CW'(pos_q);  // only used when below the count
      default:       rd_off = '0;
    endcase
  end

  always_comb begin
    sts_o.need_read = (((mode_q == MODE_POP_FRONT) || (mode_q == MODE_POP_BACK)) && !empty)
                      || ((mode_q == MODE_READ_POS) && !pos_out);
    sts_o.need_scan = (mode_q == MODE_FIND) && !empty;
    sts_o.scan_done = cmp_vld_q && (val_eq || (cmp_idx_q == PW'(cnt_m1)));
    sts_o.out_free  = !out_valid_q || out_ready_i;
  end

  // search walk: one read issued and one compare per cycle
  always_comb begin
    iss_d     = iss_q;
    addr_d    = addr_q;
    cmp_vld_d = cmp_vld_q;
    cmp_idx_d = cmp_idx_q;
    hit_d     = hit_q;
    hit_pos_d = hit_pos_q;
    if (cmd_i.scan_start) begin
      iss_d     = '0;
      addr_d    = fp_q;
      cmp_vld_d = 1'b0;
      hit_d     = 1'b0;
      hit_pos_d = '0;
    end else if (cmd_i.scan_step) begin
      if (issue) begin
        iss_d     = iss_q + CW'(1);
        addr_d    = inc_f(addr_q);
        cmp_vld_d = 1'b1;
        cmp_idx_d = PW'(iss_q);
      end else begin
        cmp_vld_d = 1'b0;
      end
      if (cmp_vld_q && val_eq && !hit_q) begin
        hit_d     = 1'b1;
        hit_pos_d = cmp_idx_q;
      end
    end
  end

  assign re    = cmd_i.rd_start || (cmd_i.scan_step && issue);
  assign raddr = cmd_i.rd_start ? slot_f(fp_q, rd_off) : addr_q;

  // result and ring update of the finished request
  always_comb begin
    res_status = ST_OK;
    res_value  = '0;
    res_fpos   = '0;
    fp_d       = fp_q;
    cnt_d      = cnt_q;
    we         = 1'b0;
    waddr      = fp_dec;
    case (mode_q)
      MODE_PUSH_FRONT: begin
        if (full) begin
          res_status = ST_FULL;
        end else begin
          we    = 1'b1;
          waddr = fp_dec;
          fp_d  = fp_dec;
          cnt_d = cnt_q + CW'(1);
        end
      end
      MODE_PUSH_BACK: begin
        if (full) begin
          res_status = ST_FULL;
        end else begin
          we    = 1'b1;
          waddr = slot_f(fp_q, cnt_q);
          cnt_d = cnt_q + CW'(1);
        end
      end
      MODE_POP_FRONT: begin
        if (empty) begin
          res_status = ST_EMPTY;
        end else begin
          res_value = rd_data;
          fp_d      = inc_f(fp_q);
          cnt_d     = cnt_m1;
        end
      end
      MODE_POP_BACK: begin
        if (empty) begin
          res_status = ST_EMPTY;
        end else begin
          res_value = rd_data;
          cnt_d     = cnt_m1;
        end
      end
      MODE_FIND: begin
        if (!empty && hit_q) begin
          res_fpos = POS_W'(hit_pos_q);
        end else begin
          res_status = ST_MISS;
        end
      end
      MODE_READ_POS: begin
        if (pos_out) begin
          res_status = ST_MISS;
        end else begin
          res_value = rd_data;
        end
      end
      default: begin
        res_status = ST_MISS;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fp_q        <= '0;
      cnt_q       <= '0;
      iss_q       <= '0;
      addr_q      <= '0;
      cmp_vld_q   <= 1'b0;
      cmp_idx_q   <= '0;
      hit_q       <= 1'b0;
      hit_pos_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.commit) begin
        fp_q  <= fp_d;
        cnt_q <= cnt_d;
      end
      iss_q       <= iss_d;
      addr_q      <= addr_d;
      cmp_vld_q   <= cmp_vld_d;
      cmp_idx_q   <= cmp_idx_d;
      hit_q       <= hit_d;
      hit_pos_q   <= hit_pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      mode_q <= req_mode_i;
      val_q  <= req_value_i;
      pos_q  <= req_pos_i;
    end
    if (cmd_i.commit) begin
      out_status_q <= res_status;
      out_value_q  <= res_value;
      out_fpos_q   <= res_fpos;
      out_count_q  <= CNT_W'(cnt_d);
    end
  end

  deq_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we && cmd_i.commit),
    .waddr_i(waddr),
    .wdata_i(val_q),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rd_data)
  );

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_value_o  = out_value_q;
  assign out_fpos_o   = out_fpos_q;
  assign out_count_o  = out_count_q;

endmodule

### hdl/double_ended_queue_with_search.sv
// Top level of the double-ended queue with search over a ring buffer.
//
//  channel  | dir | handshake                    | payload
//  ---------+-----+------------------------------+-----------------------------------------
//  request  | in  | s_axis_tvalid / s_axis_tready | tuser: mode; tdata: value, position
//  result   | out | m_axis_tvalid / m_axis_tready | tuser: status; tdata: value, found pos,
//           |     |                              |        entry count
//
// One request beat at a time. Push, pop, indexed read and every refused request pass
// through capture, execute (one memory read for a pop or an indexed read) and commit;
// the result beat is offered from the output register that commit loads.
// A find walks the ring one entry per cycle through the single RAM read port and stops
// at the first match or after the last entry.
// Reset clears the front pointer and the count; the entry memory is not cleared.
// A new request is taken while the previous result waits in the output register; the
// commit of that next request stalls until the result beat has gone.
`timescale 1ns / 1ps

module double_ended_queue_with_search #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [31:0] data_value, [37:32] position, [39:38] zero
  input  logic [deq_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  // [2:0] mode
  input  logic [deq_pkg::MODE_W-1:0]        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [31:0] result_value, [37:32] found_position, [44:38] entry_count, [47:45] zero
  output logic [deq_pkg::M_TDATA_W-1:0]     m_axis_tdata,
  // [1:0] status
  output logic [deq_pkg::STATUS_W-1:0]      m_axis_tuser
);
  import deq_pkg::*;

  dp_cmd_t             cmd;
  dp_sts_t             sts;
  logic [VALUE_W-1:0]  out_value;
  logic [POS_W-1:0]    out_fpos;
  logic [CNT_W-1:0]    out_count;

  // sequencing
  deq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(s_axis_tvalid),
    .req_ready_o(s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // ring, memory, search and output register
  deq_dp #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .req_mode_i  (s_axis_tuser),
    .req_value_i (s_axis_tdata[VALUE_W-1:0]),
    .req_pos_i   (s_axis_tdata[VALUE_W+POS_W-1:VALUE_W]),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_status_o(m_axis_tuser),
    .out_value_o (out_value),
    .out_fpos_o  (out_fpos),
    .out_count_o (out_count)
  );

  assign m_axis_tdata = {(M_TDATA_W - VALUE_W - POS_W - CNT_W)'(0), out_count, out_fpos,
                         out_value};

endmodule

### hdl/deq_checker.sv
// Port-level checker of the double-ended queue, bound to the top level.
`timescale 1ns / 1ps

module deq_checker #(
  parameter int unsigned DEPTH = 64
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [deq_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic [deq_pkg::STATUS_W-1:0]  m_axis_tuser
);
  import deq_pkg::*;

  logic [CNT_W-1:0] count;
  assign count = m_axis_tdata[VALUE_W+POS_W+CNT_W-1:VALUE_W+POS_W];

  // one request in flight: no second beat right after an accepted one
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request accepted while previous one still executing");

  // a stalled result beat holds
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  // a refused push only when the ring is full
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_FULL) |-> count == CNT_W'(DEPTH))
    else $error("full status with count below depth");

  // a refused pop only when the ring is empty
  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_EMPTY) |-> count == '0)
    else $error("empty status with entries held");

  // count never beyond the depth (checked only for DEPTH up to 127)
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (DEPTH > 127) || (32'(count) <= DEPTH))
    else $error("entry count beyond depth");

endmodule

bind double_ended_queue_with_search deq_checker #(
  .DEPTH(DEPTH)
) u_deq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);
